FILE: rtl/opa_pkg.sv
package opa_pkg;

  // Pool geometry
  localparam int PoolSize = 256;
  localparam int HandleW  = 8;
  localparam int CountW   = $clog2(PoolSize + 1);
  localparam int AddrW    = $clog2(PoolSize);

  // Command codes
  localparam logic [1:0] CmdAlloc   = 2'd0;
  localparam logic [1:0] CmdTry     = 2'd1;
  localparam logic [1:0] CmdRelease = 2'd2;

  // Status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StEmpty     = 2'd1;
  localparam logic [1:0] StInvalid   = 2'd2;
  localparam logic [1:0] StExhausted = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [HandleW-1:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [HandleW-1:0] handle_out;
    logic [1:0]         status;
  } rsp_t;

  // Free list update for one transaction
  typedef struct packed {
    logic               pop;
    logic               push;
    logic [HandleW-1:0] push_data;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

FILE: rtl/object_pool_allocator_top.sv
// Object pool allocator: hands out 8-bit object handles from a pool of 256.
// Request channel (req_valid_i / req_ready_o / req_i) carries a command and,
// for release, the handle to return. Response channel (rsp_valid_o /
// rsp_ready_i / rsp_o) returns one transaction per request: the granted
// handle and a status (ok, free list empty, invalid release, exhausted).
// Allocate reuses the oldest released handle, else a never-used one.
// Try-allocate only looks at the free list.
// A request is accepted in S_IDLE and executed in S_EXEC. The edge that
// accepts it also reads the free-list memory and the allocation bitmap
// memory; the execute cycle decides and writes back, and the response
// register loads at its end. So rsp_valid_o rises as S_EXEC completes, and
// a new request is not taken until the previous one has left S_EXEC.
// A request is taken again as soon as the previous one has finished, even
// while its response is still waiting in the output register. If the
// receiver stalls with a response still pending, the next request holds in
// the write-back cycle until the output register frees up.
// Reset clears the counters, the pointers and the bitmap valid bits at once;
// the block is ready in the first cycle after reset.
module object_pool_allocator_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  opa_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output opa_pkg::rsp_t rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e                       state_q, state_d;
  opa_pkg::req_t                req_q;
  opa_pkg::rsp_t                rsp_q, rsp_d;
  logic                         rsp_valid_q;
  logic [opa_pkg::CountW-1:0]   fresh_q, fresh_d;
  logic                         req_fire;
  logic                         exec_fire;

  // Allocation bitmap: memory plus per-entry valid bits cleared by reset
  logic                         map_mem [opa_pkg::PoolSize];
  logic [opa_pkg::PoolSize-1:0] map_vld_q;
  logic                         map_rd_q;
  logic                         map_marked;
  logic                         map_we;
  logic [opa_pkg::AddrW-1:0]    map_wa;
  logic                         map_wd;

  // Free list
  logic [opa_pkg::HandleW-1:0]  fifo_rd_data;
  opa_pkg::fifo_ctrl_t          fifo_ctrl;
  opa_pkg::fifo_stat_t          fifo_stat;

  opa_free_fifo u_free_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (req_fire),
    .rd_data_o (fifo_rd_data),
    .ctrl_i    (fifo_ctrl),
    .stat_o    (fifo_stat)
  );

  assign req_ready_o = (state_q == S_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;
  assign exec_fire   = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready_i);

  // Bitmap read data is only trusted if the entry was ever written
  assign map_marked = map_rd_q && map_vld_q[req_q.handle_in[opa_pkg::AddrW-1:0]];

  // Decide the transaction and its write-backs
  always_comb begin
    rsp_d          = '0;
    rsp_d.status   = opa_pkg::StOk;
    fresh_d        = fresh_q;
    fifo_ctrl      = '0;
    map_we         = 1'b0;
    map_wa         = '0;
    map_wd         = 1'b0;
    unique case (req_q.command) inside
      opa_pkg::CmdAlloc, opa_pkg::CmdTry: begin
        if (!fifo_stat.empty) begin
          rsp_d.handle_out = fifo_rd_data;
          fifo_ctrl.pop    = exec_fire;
          map_we           = exec_fire;
          map_wa           = fifo_rd_data[opa_pkg::AddrW-1:0];
          map_wd           = 1'b1;
        end else if (req_q.command == opa_pkg::CmdTry) begin
          rsp_d.status = opa_pkg::StEmpty;
        end else if (fresh_q < opa_pkg::CountW'(opa_pkg::PoolSize)) begin
          rsp_d.handle_out = fresh_q[opa_pkg::HandleW-1:0];
          map_we           = exec_fire;
          map_wa           = fresh_q[opa_pkg::AddrW-1:0];
          map_wd           = 1'b1;
          if (exec_fire) begin
            fresh_d = fresh_q + opa_pkg::CountW'(1);
          end
        end else begin
          rsp_d.status = opa_pkg::StExhausted;
        end
      end
      opa_pkg::CmdRelease: begin
        if (map_marked) begin
          map_we              = exec_fire;
          map_wa              = req_q.handle_in[opa_pkg::AddrW-1:0];
          map_wd              = 1'b0;
          fifo_ctrl.push      = exec_fire;
          fifo_ctrl.push_data = req_q.handle_in;
        end else begin
          rsp_d.status = opa_pkg::StInvalid;
        end
      end
      default: begin
        rsp_d.status = opa_pkg::StOk;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_fire) state_d = S_EXEC;
      S_EXEC: if (exec_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      fresh_q     <= '0;
      map_vld_q   <= '0;
    end else begin
      state_q <= state_d;
      fresh_q <= fresh_d;
      if (exec_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      if (map_we) begin
        map_vld_q[map_wa] <= 1'b1;
      end
    end
  end

  // Request and response payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= req_i;
    end
    if (exec_fire) begin
      rsp_q <= rsp_d;
    end
  end

  // Bitmap memory: write-back in the execute cycle, read on acceptance
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (req_fire) begin
      map_rd_q <= map_mem[req_i.handle_in[opa_pkg::AddrW-1:0]];
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

FILE: rtl/opa_free_fifo.sv
// Free-handle queue: one synchronous memory plus head, tail and fill count.
module opa_free_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  output logic [opa_pkg::HandleW-1:0]  rd_data_o,
  input  opa_pkg::fifo_ctrl_t          ctrl_i,
  output opa_pkg::fifo_stat_t          stat_o
);

  logic [opa_pkg::HandleW-1:0] mem [opa_pkg::PoolSize];
  logic [opa_pkg::AddrW-1:0]   head_q, head_d;
  logic [opa_pkg::AddrW-1:0]   tail_q, tail_d;
  logic [opa_pkg::CountW-1:0]  count_q, count_d;
  logic [opa_pkg::HandleW-1:0] rd_q;
  logic                        do_push;
  logic                        do_pop;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == opa_pkg::CountW'(opa_pkg::PoolSize));

  // A push with the queue full is dropped
  assign do_push = ctrl_i.push && !stat_o.full;
  assign do_pop  = ctrl_i.pop && !stat_o.empty;

  // Pointers wrap at the pool size
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (do_pop) begin
      head_d = (head_q == opa_pkg::AddrW'(opa_pkg::PoolSize - 1)) ? '0
             : head_q + opa_pkg::AddrW'(1);
    end
    if (do_push) begin
      tail_d = (tail_q == opa_pkg::AddrW'(opa_pkg::PoolSize - 1)) ? '0
             : tail_q + opa_pkg::AddrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + opa_pkg::CountW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - opa_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Storage: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[tail_q] <= ctrl_i.push_data;
    end
    if (rd_en_i) begin
      rd_q <= mem[head_q];
    end
  end

  assign rd_data_o = rd_q;

endmodule
